// ----- sv/cfpd_pkg.sv -----
package cfpd_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST     = 16'd255;
  localparam logic [7:0]  ID_TLM_RST      = 8'd1;
  localparam logic [7:0]  ID_CMD_RST      = 8'd2;
  localparam logic [7:0]  ID_ACK_RST      = 8'd3;
  localparam logic [7:0]  ID_RSP_RST      = 8'd4;
  localparam logic [7:0]  ID_EVT_RST      = 8'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [16:0] HDR_END   = 17'd11;
  localparam logic [16:0] MIN_FRAME = 17'd13;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST  = 3'd0,
    REG_SYNC_SECOND = 3'd1,
    REG_MAX_LEN     = 3'd2,
    REG_ID_TLM      = 3'd3,
    REG_ID_CMD      = 3'd4,
    REG_ID_ACK      = 3'd5,
    REG_ID_RSP      = 3'd6,
    REG_ID_EVT      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_SYNC     = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_OVERSIZE = 3'd4,
    ST_CRC      = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
    logic [7:0]  id_tlm;
    logic [7:0]  id_cmd;
    logic [7:0]  id_ack;
    logic [7:0]  id_rsp;
    logic [7:0]  id_evt;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    status_t     frame_status;
    logic [7:0]  message_ident;
    logic [15:0] payload_length;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
  } result_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/cfpd_cfg.sv -----
module cfpd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfpd_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output cfpd_pkg::cfg_t                 cfg
);

  cfpd_pkg::cfg_t     cfg_r;
  cfpd_pkg::cfg_t     cfg_nxt;
  cfpd_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = cfpd_pkg::reg_idx_t'(paddr[cfpd_pkg::ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        cfpd_pkg::REG_SYNC_FIRST:  cfg_nxt.sync_first  = pwdata[7:0];
        cfpd_pkg::REG_SYNC_SECOND: cfg_nxt.sync_second = pwdata[7:0];
        cfpd_pkg::REG_MAX_LEN:     cfg_nxt.max_len     = pwdata[15:0];
        cfpd_pkg::REG_ID_TLM:      cfg_nxt.id_tlm      = pwdata[7:0];
        cfpd_pkg::REG_ID_CMD:      cfg_nxt.id_cmd      = pwdata[7:0];
        cfpd_pkg::REG_ID_ACK:      cfg_nxt.id_ack      = pwdata[7:0];
        cfpd_pkg::REG_ID_RSP:      cfg_nxt.id_rsp      = pwdata[7:0];
        cfpd_pkg::REG_ID_EVT:      cfg_nxt.id_evt      = pwdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cfpd_pkg::REG_SYNC_FIRST:  prdata = {24'h0, cfg_r.sync_first};
      cfpd_pkg::REG_SYNC_SECOND: prdata = {24'h0, cfg_r.sync_second};
      cfpd_pkg::REG_MAX_LEN:     prdata = {16'h0, cfg_r.max_len};
      cfpd_pkg::REG_ID_TLM:      prdata = {24'h0, cfg_r.id_tlm};
      cfpd_pkg::REG_ID_CMD:      prdata = {24'h0, cfg_r.id_cmd};
      cfpd_pkg::REG_ID_ACK:      prdata = {24'h0, cfg_r.id_ack};
      cfpd_pkg::REG_ID_RSP:      prdata = {24'h0, cfg_r.id_rsp};
      cfpd_pkg::REG_ID_EVT:      prdata = {24'h0, cfg_r.id_evt};
      default:                   prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= cfpd_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= cfpd_pkg::SYNC_SECOND_RST;
      cfg_r.max_len     <= cfpd_pkg::MAX_LEN_RST;
      cfg_r.id_tlm      <= cfpd_pkg::ID_TLM_RST;
      cfg_r.id_cmd      <= cfpd_pkg::ID_CMD_RST;
      cfg_r.id_ack      <= cfpd_pkg::ID_ACK_RST;
      cfg_r.id_rsp      <= cfpd_pkg::ID_RSP_RST;
      cfg_r.id_evt      <= cfpd_pkg::ID_EVT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/cfpd_parse.sv -----
module cfpd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  cfpd_pkg::cfg_t      cfg,
  input  logic                acc,
  input  logic [7:0]          byte_in,
  input  logic                last,
  output logic                emit,
  output cfpd_pkg::result_t   res
);

  logic [16:0] cnt_r,   cnt_nxt,   cnt_inc;
  logic [15:0] crc_r,   crc_nxt,   crc_upd;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic        sync_r,  sync_nxt,  sync_upd;
  logic [7:0]  ident_r, ident_nxt, ident_upd;
  logic [15:0] len_r,   len_nxt,   len_upd;
  logic [15:0] seq_r,   seq_nxt,   seq_upd;
  logic [31:0] stamp_r, stamp_nxt, stamp_upd;

  logic [16:0] ofs;
  logic [16:0] exp_len;
  logic [15:0] got;
  logic        id_ok;
  logic        in_payload;
  cfpd_pkg::status_t st;

  // header capture by byte offset
  always_comb begin
    sync_upd  = sync_r;
    ident_upd = ident_r;
    len_upd   = len_r;
    seq_upd   = seq_r;
    stamp_upd = stamp_r;
    unique case (cnt_r)
      17'd0:   if (byte_in != cfg.sync_first)  sync_upd = 1'b0;
      17'd1:   if (byte_in != cfg.sync_second) sync_upd = 1'b0;
      17'd2:   ident_upd = byte_in;
      17'd3,
      17'd4:   len_upd = {len_r[7:0], byte_in};
      17'd5,
      17'd6:   seq_upd = {seq_r[7:0], byte_in};
      17'd7,
      17'd8,
      17'd9,
      17'd10:  stamp_upd = {stamp_r[23:0], byte_in};
      default: ;
    endcase
  end

  assign crc_upd = (cnt_r >= 17'd4) ? cfpd_pkg::crc_fold(crc_r, held0_r) : crc_r;
  assign cnt_inc = (cnt_r == cfpd_pkg::COUNT_MAX) ? cnt_r : cnt_r + 17'd1;
  assign got     = {held1_r, byte_in};
  assign exp_len = cfpd_pkg::MIN_FRAME + {1'b0, len_upd};
  assign id_ok   = (ident_upd == cfg.id_tlm) || (ident_upd == cfg.id_cmd) ||
                   (ident_upd == cfg.id_ack) || (ident_upd == cfg.id_rsp) ||
                   (ident_upd == cfg.id_evt);

  always_comb begin
    priority if (cnt_inc < cfpd_pkg::MIN_FRAME) st = cfpd_pkg::ST_LENGTH;
    else if (!sync_upd)                         st = cfpd_pkg::ST_SYNC;
    else if (!id_ok)                            st = cfpd_pkg::ST_BAD_ID;
    else if (len_upd > cfg.max_len)             st = cfpd_pkg::ST_OVERSIZE;
    else if (cnt_inc != exp_len)                st = cfpd_pkg::ST_LENGTH;
    else if (got != crc_upd)                    st = cfpd_pkg::ST_CRC;
    else                                        st = cfpd_pkg::ST_OK;
  end

  assign ofs        = cnt_r - cfpd_pkg::HDR_END;
  assign in_payload = (cnt_r >= cfpd_pkg::HDR_END) &&
                      (cnt_r < cfpd_pkg::HDR_END + {1'b0, len_r});
  assign emit       = last || in_payload;

  always_comb begin
    res = '0;
    if (last) begin
      res.kind            = cfpd_pkg::KIND_STATUS;
      res.frame_status    = st;
      res.message_ident   = ident_upd;
      res.payload_length  = len_upd;
      res.sequence_number = seq_upd;
      res.time_stamp      = stamp_upd;
    end else begin
      res.kind          = cfpd_pkg::KIND_PAYLOAD;
      res.payload_byte  = byte_in;
      res.payload_index = ofs[15:0];
    end
  end

  // end mark returns the frame state to its cleared values
  always_comb begin
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    sync_nxt  = sync_r;
    ident_nxt = ident_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    stamp_nxt = stamp_r;
    if (acc) begin
      if (last) begin
        cnt_nxt   = '0;
        crc_nxt   = cfpd_pkg::CRC_INIT;
        held0_nxt = '0;
        held1_nxt = '0;
        sync_nxt  = 1'b1;
        ident_nxt = '0;
        len_nxt   = '0;
        seq_nxt   = '0;
        stamp_nxt = '0;
      end else begin
        cnt_nxt   = cnt_inc;
        crc_nxt   = crc_upd;
        held0_nxt = held1_r;
        held1_nxt = byte_in;
        sync_nxt  = sync_upd;
        ident_nxt = ident_upd;
        len_nxt   = len_upd;
        seq_nxt   = seq_upd;
        stamp_nxt = stamp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      crc_r   <= cfpd_pkg::CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      sync_r  <= 1'b1;
      ident_r <= '0;
      len_r   <= '0;
      seq_r   <= '0;
      stamp_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      sync_r  <= sync_nxt;
      ident_r <= ident_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule

// ----- sv/cfpd_obuf.sv -----
module cfpd_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cfpd_pkg::result_t   res_in,
  output logic                can_take,
  output logic                vld,
  input  logic                rdy,
  output cfpd_pkg::result_t   res_out
);

  logic              vld_r, vld_nxt;
  cfpd_pkg::result_t res_r, res_nxt;

  assign can_take = !vld_r || rdy;
  assign vld      = vld_r;
  assign res_out  = res_r;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (can_take) begin
      vld_nxt = load;
      if (load) begin
        res_nxt = res_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ----- sv/crc_framed_packet_decoder.sv -----
// channel | handshake              | beat
// in      | in_valid / in_ready    | in_byte, in_frame_end
// out     | out_valid / out_ready  | out_result_kind .. out_time_stamp
// cfg     | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle; header, CRC-16 byte update and all frame checks are
// evaluated in the accept cycle and land in the output register.
// A result shows on out in the cycle after its byte is accepted.
// in_ready drops only while a result sits in the output register and
// out_ready is low. Synchronous active-low reset; no clearing pass.
module crc_framed_packet_decoder (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic                         in_frame_end,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [7:0]                   out_payload_byte,
  output logic [15:0]                  out_payload_index,
  output logic [2:0]                   out_frame_status,
  output logic [7:0]                   out_message_ident,
  output logic [15:0]                  out_payload_length,
  output logic [15:0]                  out_sequence_number,
  output logic [31:0]                  out_time_stamp,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cfpd_pkg::cfg_t    cfg;
  cfpd_pkg::result_t res;
  cfpd_pkg::result_t res_q;
  logic              acc;
  logic              emit;
  logic              can_take;

  assign in_ready = can_take;
  assign acc      = in_valid && can_take;

  cfpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfpd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .acc     (acc),
    .byte_in (in_byte),
    .last    (in_frame_end),
    .emit    (emit),
    .res     (res)
  );

  cfpd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc && emit),
    .res_in   (res),
    .can_take (can_take),
    .vld      (out_valid),
    .rdy      (out_ready),
    .res_out  (res_q)
  );

  assign out_result_kind     = res_q.kind;
  assign out_payload_byte    = res_q.payload_byte;
  assign out_payload_index   = res_q.payload_index;
  assign out_frame_status    = res_q.frame_status;
  assign out_message_ident   = res_q.message_ident;
  assign out_payload_length  = res_q.payload_length;
  assign out_sequence_number = res_q.sequence_number;
  assign out_time_stamp      = res_q.time_stamp;

endmodule

// ----- sv/cfpd_chk.sv -----
module cfpd_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_result_kind,
  input logic [7:0]                   out_payload_byte,
  input logic [15:0]                  out_payload_index,
  input logic [2:0]                   out_frame_status,
  input logic [7:0]                   out_message_ident,
  input logic [15:0]                  out_payload_length,
  input logic [15:0]                  out_sequence_number,
  input logic [31:0]                  out_time_stamp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_payload_byte) && $stable(out_payload_index) &&
      $stable(out_frame_status) && $stable(out_time_stamp))
    else $error("result beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with room in output register");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == cfpd_pkg::KIND_PAYLOAD) |->
      out_frame_status == cfpd_pkg::ST_OK && out_message_ident == 8'h00 &&
      out_payload_length == 16'h0000 && out_sequence_number == 16'h0000 &&
      out_time_stamp == 32'h0)
    else $error("payload beat carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == cfpd_pkg::KIND_STATUS) |->
      out_payload_byte == 8'h00 && out_payload_index == 16'h0000 &&
      out_frame_status <= cfpd_pkg::ST_CRC)
    else $error("status beat malformed");

endmodule

bind crc_framed_packet_decoder cfpd_chk u_cfpd_chk (.*);
